// ===== design/glrh_pkg.sv =====
`default_nettype none
package glrh_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_X     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_INDEX = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL_LO      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL_HI      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_LEN     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPANS   = 3'd5;

  // Fixed field widths
  localparam int unsigned ADV_W   = 16;
  localparam int unsigned SPANS_W = 8;

  // Result kinds
  localparam logic KIND_SPAN    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // What one queued bundle carries
  typedef struct packed {
    logic has_span;
    logic has_sum;
  } res_flags_t;

endpackage
`default_nettype wire

// ===== design/glrh_in_if.sv =====
`default_nettype none
interface glrh_in_if #(
  parameter int unsigned INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         glyph_present;
  logic signed [INDEX_BITS:0]   cluster_index;
  logic signed [15:0]           advance;
  logic                         end_of_string;

  modport source (output valid, glyph_present, cluster_index, advance, end_of_string,
                  input ready);
  modport sink   (input valid, glyph_present, cluster_index, advance, end_of_string,
                  output ready);
endinterface
`default_nettype wire

// ===== design/glrh_out_if.sv =====
`default_nettype none
interface glrh_out_if #(
  parameter int unsigned PEN_BITS   = 24,
  parameter int unsigned INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic signed [PEN_BITS-1:0]   span_start;
  logic signed [PEN_BITS-1:0]   span_end;
  logic signed [PEN_BITS-1:0]   total_width;
  logic signed [INDEX_BITS:0]   hit_index;
  logic signed [PEN_BITS-1:0]   index_x;
  logic                         last_result;

  modport source (output valid, result_kind, span_start, span_end, total_width,
                  hit_index, index_x, last_result,
                  input ready);
  modport sink   (input valid, result_kind, span_start, span_end, total_width,
                  hit_index, index_x, last_result,
                  output ready);
endinterface
`default_nettype wire

// ===== design/glrh_cfg_if.sv =====
`default_nettype none
interface glrh_cfg_if #(
  parameter int unsigned DATA_W = 24
);
  logic              valid;
  logic              ready;
  logic [2:0]        addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== design/glrh_front.sv =====
`default_nettype none
module glrh_front #(
  parameter int unsigned PEN_BITS   = 24,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  glrh_in_if.sink                             in_ch,
  input  wire logic signed [PEN_BITS-1:0]     query_x,
  input  wire logic [INDEX_BITS-1:0]          query_index,
  input  wire logic [INDEX_BITS-1:0]          sel_lo,
  input  wire logic [INDEX_BITS-1:0]          sel_hi,
  input  wire logic [INDEX_BITS-1:0]          src_len,
  input  wire logic [glrh_pkg::SPANS_W-1:0]   max_spans,
  input  wire logic                           q_ready,
  output logic                                push,
  output glrh_pkg::res_flags_t                push_flags,
  output logic signed [PEN_BITS-1:0]          push_span_start,
  output logic signed [PEN_BITS-1:0]          push_span_end,
  output logic signed [PEN_BITS-1:0]          push_total,
  output logic signed [INDEX_BITS:0]          push_hit,
  output logic signed [PEN_BITS-1:0]          push_index_x
);
  import glrh_pkg::*;

  localparam logic signed [PEN_BITS-1:0] PEN_MAX = {1'b0, {(PEN_BITS-1){1'b1}}};
  localparam logic signed [PEN_BITS-1:0] PEN_MIN = {1'b1, {(PEN_BITS-1){1'b0}}};
  localparam logic signed [INDEX_BITS:0] NO_HIT  = '1;

  logic signed [PEN_BITS-1:0] pen_r, pen_nxt;
  logic                       insel_r, insel_nxt;
  logic signed [PEN_BITS-1:0] start_r, start_nxt;
  logic [SPANS_W-1:0]         spans_r, spans_nxt;
  logic                       hit_done_r, hit_done_nxt;
  logic signed [INDEX_BITS:0] hit_val_r, hit_val_nxt;
  logic                       idx_found_r, idx_found_nxt;
  logic signed [PEN_BITS-1:0] idx_pen_r, idx_pen_nxt;

  logic                       accept;
  logic signed [PEN_BITS:0]   sum_w;
  logic signed [PEN_BITS-1:0] next_pen;
  logic                       neg;
  logic [INDEX_BITS-1:0]      clu;
  logic                       enabled, sel;
  logic                       span_run, span_eos;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  assign sum_w = $signed({pen_r[PEN_BITS-1], pen_r})
               + $signed({{(PEN_BITS+1-ADV_W){in_ch.advance[ADV_W-1]}}, in_ch.advance});
  assign next_pen = (sum_w[PEN_BITS] != sum_w[PEN_BITS-1])
                  ? (sum_w[PEN_BITS] ? PEN_MIN : PEN_MAX)
                  : sum_w[PEN_BITS-1:0];

  assign neg     = in_ch.cluster_index[INDEX_BITS];
  assign clu     = in_ch.cluster_index[INDEX_BITS-1:0];
  assign enabled = (max_spans != '0) && (sel_hi > sel_lo);
  assign sel     = enabled && !neg && (clu >= sel_lo) && (clu < sel_hi);

  always_comb begin
    pen_nxt       = pen_r;
    insel_nxt     = insel_r;
    start_nxt     = start_r;
    spans_nxt     = spans_r;
    hit_done_nxt  = hit_done_r;
    hit_val_nxt   = hit_val_r;
    idx_found_nxt = idx_found_r;
    idx_pen_nxt   = idx_pen_r;
    span_run      = 1'b0;
    span_eos      = 1'b0;

    if (in_ch.glyph_present) begin
      if (sel && !insel_r) begin
        start_nxt = pen_r;
        insel_nxt = 1'b1;
      end else if (!sel && insel_r) begin
        if (spans_r < max_spans) begin
          span_run  = 1'b1;
          spans_nxt = spans_r + 1'b1;
        end
        insel_nxt = 1'b0;
      end
      if (!hit_done_r && (query_x < next_pen)) begin
        hit_done_nxt = 1'b1;
        hit_val_nxt  = (neg || (clu >= src_len)) ? NO_HIT : in_ch.cluster_index;
      end
      if (!idx_found_r && !neg && (clu == query_index)) begin
        idx_found_nxt = 1'b1;
        idx_pen_nxt   = pen_r;
      end
      pen_nxt = next_pen;
    end

    if (in_ch.end_of_string) begin
      span_eos = insel_nxt && (spans_nxt < max_spans);
    end

    // Summary from the updated state, span from whichever case closed a run
    push_flags.has_span = span_run || span_eos;
    push_flags.has_sum  = in_ch.end_of_string;
    push_span_start     = span_run ? start_r : start_nxt;
    push_span_end       = span_run ? pen_r : pen_nxt;
    push_total          = pen_nxt;
    push_hit            = hit_done_nxt ? hit_val_nxt : NO_HIT;
    push_index_x        = idx_found_nxt ? idx_pen_nxt : pen_nxt;

    // Start the next string afresh
    if (in_ch.end_of_string) begin
      pen_nxt       = '0;
      insel_nxt     = 1'b0;
      start_nxt     = '0;
      spans_nxt     = '0;
      hit_done_nxt  = 1'b0;
      hit_val_nxt   = NO_HIT;
      idx_found_nxt = 1'b0;
      idx_pen_nxt   = '0;
    end
  end

  assign push = accept && (push_flags.has_span || push_flags.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r       <= '0;
      insel_r     <= 1'b0;
      start_r     <= '0;
      spans_r     <= '0;
      hit_done_r  <= 1'b0;
      hit_val_r   <= NO_HIT;
      idx_found_r <= 1'b0;
      idx_pen_r   <= '0;
    end else if (accept) begin
      pen_r       <= pen_nxt;
      insel_r     <= insel_nxt;
      start_r     <= start_nxt;
      spans_r     <= spans_nxt;
      hit_done_r  <= hit_done_nxt;
      hit_val_r   <= hit_val_nxt;
      idx_found_r <= idx_found_nxt;
      idx_pen_r   <= idx_pen_nxt;
    end
  end

  a_spans_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && push_flags.has_span) |-> (spans_r < max_spans))
    else $error("span emitted beyond limit");
  a_hit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !hit_done_r |-> (hit_val_r == NO_HIT))
    else $error("hit value set without hit");
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_string) |=> (pen_r == '0) && !insel_r && (spans_r == '0))
    else $error("string state not cleared at end of string");

endmodule
`default_nettype wire

// ===== design/glrh_back.sv =====
`default_nettype none
module glrh_back #(
  parameter int unsigned PEN_BITS    = 24,
  parameter int unsigned INDEX_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire glrh_pkg::res_flags_t           push_flags,
  input  wire logic signed [PEN_BITS-1:0]     push_span_start,
  input  wire logic signed [PEN_BITS-1:0]     push_span_end,
  input  wire logic signed [PEN_BITS-1:0]     push_total,
  input  wire logic signed [INDEX_BITS:0]     push_hit,
  input  wire logic signed [PEN_BITS-1:0]     push_index_x,
  output logic                                q_ready,
  glrh_out_if.source                          out_ch
);
  import glrh_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  res_flags_t                 flags_q [QUEUE_DEPTH];
  logic signed [PEN_BITS-1:0] start_q [QUEUE_DEPTH];
  logic signed [PEN_BITS-1:0] end_q   [QUEUE_DEPTH];
  logic signed [PEN_BITS-1:0] total_q [QUEUE_DEPTH];
  logic signed [INDEX_BITS:0] hit_q   [QUEUE_DEPTH];
  logic signed [PEN_BITS-1:0] ix_q    [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;

  res_flags_t head;
  logic       send_span;
  logic       out_fire;
  logic       pop;

  assign q_ready = (cnt_r != FULL_CNT);
  assign head    = flags_q[rd_ptr_r];

  // Span goes first when the bundle has one and it has not yet left
  assign send_span = head.has_span && !phase_r;

  always_comb begin
    out_ch.valid       = (cnt_r != '0);
    out_ch.result_kind = send_span ? KIND_SPAN : KIND_SUMMARY;
    out_ch.span_start  = send_span ? start_q[rd_ptr_r] : '0;
    out_ch.span_end    = send_span ? end_q[rd_ptr_r] : '0;
    out_ch.total_width = send_span ? '0 : total_q[rd_ptr_r];
    out_ch.hit_index   = send_span ? '0 : hit_q[rd_ptr_r];
    out_ch.index_x     = send_span ? '0 : ix_q[rd_ptr_r];
    out_ch.last_result = !send_span || !head.has_sum;
  end

  assign out_fire = out_ch.valid && out_ch.ready;
  assign pop      = out_fire && out_ch.last_result;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      phase_nxt  = 1'b0;
    end else if (out_fire) begin
      phase_nxt = 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      flags_q[wr_ptr_r] <= push_flags;
      start_q[wr_ptr_r] <= push_span_start;
      end_q[wr_ptr_r]   <= push_span_end;
      total_q[wr_ptr_r] <= push_total;
      hit_q[wr_ptr_r]   <= push_hit;
      ix_q[wr_ptr_r]    <= push_index_x;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != FULL_CNT))
    else $error("push into full queue");
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (cnt_r != '0) && head.has_span && head.has_sum)
    else $error("second half pending without a two-result bundle");

endmodule
`default_nettype wire

// ===== design/glyph_run_hit_test_and_selection.sv =====
`default_nettype none
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      glyph_present, cluster_index, advance, end_of_string
// out_ch    out  valid/ready      result_kind, span_start, span_end, total_width,
//                                 hit_index, index_x, last_result
// cfg_ch    in   valid/ready      addr (register index), data
//
// One glyph is taken per cycle while the result queue has room; the front updates the
// pen and selection state in the cycle of acceptance and queues at most one bundle.
// A bundle holding both a span and a summary leaves as two results, span first,
// one result per cycle while out_ch is ready; a glyph's results queue on acceptance.
// Reset is synchronous; cfg_ch is always ready and needs no clearing pass.
// A stalled out_ch backs the queue up; in_ch ready drops only when QUEUE_DEPTH
// bundles are waiting.
module glyph_run_hit_test_and_selection #(
  parameter int unsigned PEN_BITS    = 24,
  parameter int unsigned INDEX_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  glrh_in_if.sink    in_ch,
  glrh_out_if.source out_ch,
  glrh_cfg_if.sink   cfg_ch
);
  import glrh_pkg::*;

  logic signed [PEN_BITS-1:0] query_x_r;
  logic [INDEX_BITS-1:0]      query_index_r;
  logic [INDEX_BITS-1:0]      sel_lo_r;
  logic [INDEX_BITS-1:0]      sel_hi_r;
  logic [INDEX_BITS-1:0]      src_len_r;
  logic [SPANS_W-1:0]         max_spans_r;

  logic                       q_ready;
  logic                       push;
  res_flags_t                 push_flags;
  logic signed [PEN_BITS-1:0] push_span_start;
  logic signed [PEN_BITS-1:0] push_span_end;
  logic signed [PEN_BITS-1:0] push_total;
  logic signed [INDEX_BITS:0] push_hit;
  logic signed [PEN_BITS-1:0] push_index_x;

  // Register writes are never stalled
  assign cfg_ch.ready = 1'b1;

  // Unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r     <= '0;
      query_index_r <= '0;
      sel_lo_r      <= '0;
      sel_hi_r      <= '0;
      src_len_r     <= '0;
      max_spans_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_QUERY_X:     query_x_r     <= cfg_ch.data[PEN_BITS-1:0];
        REG_QUERY_INDEX: query_index_r <= cfg_ch.data[INDEX_BITS-1:0];
        REG_SEL_LO:      sel_lo_r      <= cfg_ch.data[INDEX_BITS-1:0];
        REG_SEL_HI:      sel_hi_r      <= cfg_ch.data[INDEX_BITS-1:0];
        REG_SRC_LEN:     src_len_r     <= cfg_ch.data[INDEX_BITS-1:0];
        REG_MAX_SPANS:   max_spans_r   <= cfg_ch.data[SPANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: pen, selection runs, hit test and index lookup
  glrh_front #(
    .PEN_BITS   (PEN_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .query_x         (query_x_r),
    .query_index     (query_index_r),
    .sel_lo          (sel_lo_r),
    .sel_hi          (sel_hi_r),
    .src_len         (src_len_r),
    .max_spans       (max_spans_r),
    .q_ready         (q_ready),
    .push            (push),
    .push_flags      (push_flags),
    .push_span_start (push_span_start),
    .push_span_end   (push_span_end),
    .push_total      (push_total),
    .push_hit        (push_hit),
    .push_index_x    (push_index_x)
  );

  // Back: bundle queue and result sequencing
  glrh_back #(
    .PEN_BITS    (PEN_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_flags      (push_flags),
    .push_span_start (push_span_start),
    .push_span_end   (push_span_end),
    .push_total      (push_total),
    .push_hit        (push_hit),
    .push_index_x    (push_index_x),
    .q_ready         (q_ready),
    .out_ch          (out_ch)
  );

endmodule
`default_nettype wire
